FILE: hdl/pgs_pkg.sv
// ----------------------------------------------------------------------------
// pgs_pkg
// Types, constants and the root digit step for the gamma 2 pixel unit.
// ----------------------------------------------------------------------------
package pgs_pkg;

   localparam int CHAN_WIDTH      = 16;
   localparam int BYTE_WIDTH      = 8;
   localparam int NUM_STAGES      = 4;
   localparam int STEPS_PER_STAGE = 2;
   localparam int NUM_STEPS       = NUM_STAGES * STEPS_PER_STAGE;

   // weight of the first root digit, squared: 1 << 14
   localparam logic [CHAN_WIDTH-1:0] FIRST_BIT = 16'h4000;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red_linear;
      logic [CHAN_WIDTH-1:0] green_linear;
      logic [CHAN_WIDTH-1:0] blue_linear;
      logic                  last_pixel;
   } pgs_req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] red_out;
      logic [BYTE_WIDTH-1:0] green_out;
      logic [BYTE_WIDTH-1:0] blue_out;
      logic                  last_out;
   } pgs_rsp_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] rem;
      logic [CHAN_WIDTH-1:0] root;
   } pgs_root_state_type;

   // One restoring digit step of the integer square root.
   function automatic pgs_root_state_type root_step(
      input pgs_root_state_type st,
      input logic [CHAN_WIDTH-1:0] bit_val
   );
      pgs_root_state_type   nx;
      logic [CHAN_WIDTH:0]  trial;
      trial = {1'b0, st.root} + {1'b0, bit_val};
      if ({1'b0, st.rem} >= trial) begin
         nx.rem  = st.rem - trial[CHAN_WIDTH-1:0];
         nx.root = (st.root >> 1) + bit_val;
      end else begin
         nx.rem  = st.rem;
         nx.root = st.root >> 1;
      end
      return nx;
   endfunction

endpackage

FILE: hdl/pixel_gamma_sqrt_to_u8_unit.sv
// ----------------------------------------------------------------------------
// pixel_gamma_sqrt_to_u8_unit
// Gamma 2 correction of a linear RGB pixel to three 8-bit channels.
// ----------------------------------------------------------------------------
// Usage:
//   Present a pixel on req_data and raise start; the item is taken at any
//   rising edge with start high and busy low. busy is always low, so one
//   pixel may be offered every cycle.
//   Each channel goes through a four stage square root pipeline, two root
//   digits per stage. The result appears on rsp_data with rsp_strobe high
//   for exactly one cycle, once the item has passed through the register
//   of every stage, and is taken by the receiver at the clock edge that
//   closes that strobe cycle.
//   Throughput is one pixel per clock; the digit chain of the root sets the
//   pipeline depth.
//   The receiver cannot stall: every result must be captured in its strobe
//   cycle.
//   Synchronous reset clears the valid bits, so no strobe follows reset
//   until new items arrive; items in flight are dropped.
//   last_pixel travels alongside the pixel and comes out as last_out.
// ----------------------------------------------------------------------------
module pixel_gamma_sqrt_to_u8_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pgs_pkg::pgs_req_type req_data,
   output logic                 rsp_strobe,
   output pgs_pkg::pgs_rsp_type rsp_data
);
   import pgs_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] last_ff;
   logic                  accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign valid_in = {valid_ff[NUM_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= {last_ff[NUM_STAGES-2:0], req_data.last_pixel};
   end

   pgs_isqrt_pipe u_red (
      .clock (clock),
      .value (req_data.red_linear),
      .root  (rsp_data.red_out)
   );

   pgs_isqrt_pipe u_green (
      .clock (clock),
      .value (req_data.green_linear),
      .root  (rsp_data.green_out)
   );

   pgs_isqrt_pipe u_blue (
      .clock (clock),
      .value (req_data.blue_linear),
      .root  (rsp_data.blue_out)
   );

   assign rsp_data.last_out = last_ff[NUM_STAGES-1];
   assign rsp_strobe        = valid_ff[NUM_STAGES-1];

   // every accepted item comes out exactly after the pipeline depth
   a_item_out : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("accepted item did not come out after four cycles");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 4))
      else $error("result strobe without an accepted item");

   a_last_follows : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.last_out == $past(req_data.last_pixel, 4))
      else $error("last marker does not match its item");

   a_red_floor : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ({8'd0, rsp_data.red_out} * {8'd0, rsp_data.red_out}
            <= $past(req_data.red_linear, 4)) &&
         (({9'd0, rsp_data.red_out} + 17'd1) * ({9'd0, rsp_data.red_out} + 17'd1)
            > {1'b0, $past(req_data.red_linear, 4)}))
      else $error("red root is not the floor square root");

endmodule

FILE: hdl/pgs_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// pgs_isqrt_pipe
// Pipelined floor square root of one 16-bit channel, two digits per stage.
// ----------------------------------------------------------------------------
module pgs_isqrt_pipe (
   input  logic                          clock,
   input  logic [pgs_pkg::CHAN_WIDTH-1:0] value,
   output logic [pgs_pkg::BYTE_WIDTH-1:0] root
);
   import pgs_pkg::*;

   pgs_root_state_type stage_ff [NUM_STAGES];
   pgs_root_state_type stage_in [NUM_STAGES];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      pgs_root_state_type head;

      if (s == 0) begin : g_first
         assign head.rem  = value;
         assign head.root = '0;
      end else begin : g_next
         assign head = stage_ff[s-1];
      end

      always_comb begin
         pgs_root_state_type st;
         st = head;
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            st = root_step(st, FIRST_BIT >> (2 * (s * STEPS_PER_STAGE + k)));
         end
         stage_in[s] = st;
      end

      always_ff @(posedge clock) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   assign root = stage_ff[NUM_STAGES-1].root[BYTE_WIDTH-1:0];

endmodule

FILE: tb/sv/tb_pixel_gamma_sqrt_to_u8_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_gamma_sqrt_to_u8_unit
// Self-checking bench for the gamma 2 pixel unit.
// A short table of pixels covers the channel extremes, exact squares and
// their neighbours, and the last-pixel marker. Random pixels follow, biased
// toward root boundaries and range ends, and are sent in bursts with random
// gaps. Typed table rows give their bytes, the rest an integer root computed
// here; all are matched field by field against the strobed results, in order.
// ----------------------------------------------------------------------------
module tb_pixel_gamma_sqrt_to_u8_unit;

   import pgs_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 1500;
   localparam int TAIL_CYCLES  = 8;
   localparam int DRAIN_LIMIT  = 200;
   localparam int WATCHDOG_NS  = 2_000_000;

   typedef struct {
      pgs_req_type px;
      bit          typed;
      pgs_rsp_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   pgs_req_type req_data;
   logic        rsp_strobe;
   pgs_rsp_type rsp_data;

   // carried alongside each item so the monitor knows which expectation to use
   bit          typed_row;
   pgs_rsp_type typed_rsp;

   pgs_rsp_type pending_pixels [$];
   pgs_rsp_type oldest;
   int          mismatch_count;
   int          pixels_sent;
   int          results_checked;
   int          last_markers;

   pixel_gamma_sqrt_to_u8_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #WATCHDOG_NS;
      $display("timeout with %0d results outstanding", pending_pixels.size());
      $display("status: fail");
      $finish;
   end

   // floor of the square root, built one result bit at a time from the top
   function automatic logic [7:0] floor_root8(input logic [15:0] level);
      logic [7:0] root;
      int         b;
      root = '0;
      for (b = 7; b >= 0; b--) begin
         root[b] = 1'b1;
         if (int'(root) * int'(root) > int'(level))
            root[b] = 1'b0;
      end
      return root;
   endfunction

   function automatic pgs_rsp_type gamma_correct(input pgs_req_type px);
      pgs_rsp_type res;
      res.red_out   = floor_root8(px.red_linear);
      res.green_out = floor_root8(px.green_linear);
      res.blue_out  = floor_root8(px.blue_linear);
      res.last_out  = px.last_pixel;
      return res;
   endfunction

   // bias toward exact squares, their neighbours and the range ends
   function automatic logic [15:0] pick_level();
      int mode;
      int k;
      int v;
      mode = $urandom_range(0, 99);
      if (mode < 40) begin
         v = $urandom_range(0, 65535);
      end else if (mode < 70) begin
         k = $urandom_range(0, 255);
         case ($urandom_range(0, 3))
            0:       v = k * k;
            1:       v = k * k - 1;
            2:       v = k * k + 1;
            default: v = k * k + 2 * k;
         endcase
      end else if (mode < 85) begin
         if ($urandom_range(0, 1) == 1)
            v = $urandom_range(0, 15);
         else
            v = 65535 - int'($urandom_range(0, 15));
      end else begin
         v = $urandom_range(0, 1023);
      end
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return v[15:0];
   endfunction

   function automatic pgs_req_type random_pixel();
      pgs_req_type px;
      px.red_linear   = pick_level();
      px.green_linear = pick_level();
      px.blue_linear  = pick_level();
      px.last_pixel   = ($urandom_range(0, 7) == 0);
      return px;
   endfunction

   function automatic stim_row_type stim_row(
      input int r, input int g, input int b, input bit lp,
      input bit typed, input int ro, input int go, input int bo
   );
      stim_row_type row;
      row.px.red_linear   = r[15:0];
      row.px.green_linear = g[15:0];
      row.px.blue_linear  = b[15:0];
      row.px.last_pixel   = lp;
      row.typed           = typed;
      row.want.red_out    = ro[7:0];
      row.want.green_out  = go[7:0];
      row.want.blue_out   = bo[7:0];
      row.want.last_out   = lp;
      return row;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_byte(input string name, input logic [7:0] got,
                             input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d on result %0d",
                                   name, got, want, results_checked));
   endtask

   // hold the item until a rising edge with busy low takes it
   task automatic send_pixel(input pgs_req_type px, input bit typed,
                             input pgs_rsp_type want);
      @(negedge clock);
      start     <= 1'b1;
      req_data  <= px;
      typed_row <= typed;
      typed_rsp <= want;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= random_pixel();
      end
   endtask

   task automatic drain_pending();
      int waited;
      waited = 0;
      @(negedge clock);
      start <= 1'b0;
      while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && busy === 1'b0) begin
            if (typed_row)
               pending_pixels.push_back(typed_rsp);
            else
               pending_pixels.push_back(gamma_correct(req_data));
            pixels_sent++;
            if (req_data.last_pixel)
               last_markers++;
         end
         if (rsp_strobe === 1'b1) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("result strobed with nothing outstanding");
            end else begin
               oldest = pending_pixels.pop_front();
               check_byte("red_out", rsp_data.red_out, oldest.red_out);
               check_byte("green_out", rsp_data.green_out, oldest.green_out);
               check_byte("blue_out", rsp_data.blue_out, oldest.blue_out);
               if (rsp_data.last_out !== oldest.last_out)
                  report_mismatch($sformatf("last_out got %b want %b on result %0d",
                                            rsp_data.last_out, oldest.last_out,
                                            results_checked));
               results_checked++;
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_mismatch("rsp_strobe unknown");
         end
      end
   end

   initial begin
      stim_row_type directed [];
      int           sent;
      int           burst;
      int           i;

      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      typed_row       = 1'b0;
      typed_rsp       = '0;
      mismatch_count  = 0;
      pixels_sent     = 0;
      results_checked = 0;
      last_markers    = 0;

      directed = new [14];
      directed[0]  = stim_row(0, 0, 0, 1'b0, 1'b1, 0, 0, 0);
      directed[1]  = stim_row(65535, 65535, 65535, 1'b1, 1'b1, 255, 255, 255);
      directed[2]  = stim_row(1, 2, 3, 1'b0, 1'b1, 1, 1, 1);
      directed[3]  = stim_row(4, 8, 9, 1'b0, 1'b1, 2, 2, 3);
      directed[4]  = stim_row(65025, 65024, 65534, 1'b0, 1'b1, 255, 254, 255);
      directed[5]  = stim_row(16384, 16383, 256, 1'b1, 1'b1, 128, 127, 16);
      directed[6]  = stim_row(65535, 0, 32768, 1'b1, 1'b1, 255, 0, 181);
      directed[7]  = stim_row(4096, 1024, 64, 1'b0, 1'b1, 64, 32, 8);
      directed[8]  = stim_row(16'hAAAA, 16'h5555, 16'h00FF, 1'b0, 1'b0, 0, 0, 0);
      directed[9]  = stim_row(16'hFF00, 16'h00FF, 16'hF0F0, 1'b1, 1'b0, 0, 0, 0);
      directed[10] = stim_row(16'h0002, 16'h0010, 16'h0800, 1'b0, 1'b0, 0, 0, 0);
      directed[11] = stim_row(16'h8001, 16'h7FFF, 16'hFFFE, 1'b0, 1'b0, 0, 0, 0);
      directed[12] = stim_row(16'h1234, 16'hEDCB, 16'h0F0F, 1'b1, 1'b0, 0, 0, 0);
      directed[13] = stim_row(255, 1023, 4095, 1'b0, 1'b0, 0, 0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // back to back through the table, then let the pipe empty
      foreach (directed[n])
         send_pixel(directed[n].px, directed[n].typed, directed[n].want);
      drain_pending();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            send_pixel(random_pixel(), 1'b0, '0);
            sent++;
            if (sent == RANDOM_ITEMS / 2)
               drain_pending();
         end
         // leave some bursts joined with no gap at all
         if ($urandom_range(0, 3) != 0)
            idle_cycles($urandom_range(1, 6));
      end

      drain_pending();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_pixels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));

      $display("pixels sent %0d (%0d from the table), %0d with last marker set",
               pixels_sent, directed.size(), last_markers);
      $display("results checked %0d, mismatches %0d", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/pgs_pkg.sv
hdl/pgs_isqrt_pipe.sv
hdl/pixel_gamma_sqrt_to_u8_unit.sv
tb/sv/tb_pixel_gamma_sqrt_to_u8_unit.sv
